>>> rtl/spoq_pkg.sv
// ----------------------------------------------------------------------------
// spoq_pkg
// Shared constants, codes and types of the strict priority order queue.
// ----------------------------------------------------------------------------
package spoq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_LEVELS  = 4;
   localparam int STORE_SIZE  = NUM_LEVELS * QUEUE_DEPTH;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int ADDR_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int TOTAL_W = $clog2(STORE_SIZE + 1);

   localparam int ID_W        = 16;
   localparam int ITEM_W      = 8;
   localparam int THRESH_W    = 8;
   localparam int STATUS_W    = 2;
   localparam int LEVEL_OUT_W = 2;
   localparam int TOTAL_OUT_W = 9;
   localparam int CLASS_W     = 3;

   localparam logic [THRESH_W-1:0] BULK_THRESHOLD_RESET = 8'd10;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   localparam logic [CLASS_W-1:0] LEVEL_FAVOR   = 3'd0;
   localparam logic [CLASS_W-1:0] LEVEL_BULK    = 3'd1;
   localparam logic [CLASS_W-1:0] LEVEL_FAST    = 3'd2;
   localparam logic [CLASS_W-1:0] LEVEL_REGULAR = 3'd3;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   order_id;
      logic [ITEM_W-1:0] item_count;
      logic              favor;
      logic              fast_shipping;
   } entry_type;

   typedef struct packed {
      logic      func;
      entry_type entry;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [LVL_W-1:0]   level;
      logic [TOTAL_W-1:0] total;
      logic               deq_hit;
   } result_meta_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_cmd_type;

endpackage

>>> rtl/spoq_req_if.sv
// ----------------------------------------------------------------------------
// spoq_req_if
// Request channel: enqueue or dequeue transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spoq_req_if
   import spoq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ID_W-1:0]   order_id;
   logic [ITEM_W-1:0] item_count;
   logic              favor;
   logic              fast_shipping;

   modport source (
      output valid, func, order_id, item_count, favor, fast_shipping,
      input  ready
   );

   modport sink (
      input  valid, func, order_id, item_count, favor, fast_shipping,
      output ready
   );
endinterface

>>> rtl/spoq_rsp_if.sv
// ----------------------------------------------------------------------------
// spoq_rsp_if
// Response channel: one result transaction per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spoq_rsp_if
   import spoq_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [LEVEL_OUT_W-1:0] level;
   logic [ID_W-1:0]        out_order_id;
   logic [ITEM_W-1:0]      out_item_count;
   logic                   out_favor;
   logic                   out_fast_shipping;
   logic [TOTAL_OUT_W-1:0] total_queued;

   modport source (
      output valid, status, level, out_order_id, out_item_count, out_favor,
             out_fast_shipping, total_queued,
      input  ready
   );

   modport sink (
      input  valid, status, level, out_order_id, out_item_count, out_favor,
             out_fast_shipping, total_queued,
      output ready
   );
endinterface

>>> rtl/spoq_store.sv
// ----------------------------------------------------------------------------
// spoq_store
// Entry memory for all levels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spoq_store
   import spoq_pkg::*;
(
   input  logic          clock,
   input  store_cmd_type cmd,
   output entry_type     rd_data
);

   entry_type mem [STORE_SIZE];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/spoq_ctrl.sv
// ----------------------------------------------------------------------------
// spoq_ctrl
// Classification, priority pick and per-level head, tail and count state.
// ----------------------------------------------------------------------------
module spoq_ctrl
   import spoq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [THRESH_W-1:0] csr_write_data,
   input  logic                exec,
   input  req_type             req,
   output store_cmd_type       cmd,
   output result_meta_type     meta
);

   logic [THRESH_W-1:0] threshold_ff;
   logic [PTR_W-1:0]    head_ff  [NUM_LEVELS];
   logic [PTR_W-1:0]    head_in  [NUM_LEVELS];
   logic [PTR_W-1:0]    tail_ff  [NUM_LEVELS];
   logic [PTR_W-1:0]    tail_in  [NUM_LEVELS];
   logic [CNT_W-1:0]    count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]    count_in [NUM_LEVELS];
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;
   logic [TOTAL_W-1:0]  count_sum;

   logic [CLASS_W-1:0]  class_raw;
   logic [LVL_W-1:0]    class_lvl;
   logic [LVL_W-1:0]    pick_lvl;
   logic                pick_found;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lv,
                                                    input logic [PTR_W-1:0] p);
      return ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= BULK_THRESHOLD_RESET;
      end else if (csr_write_en) begin
         threshold_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         total_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
         total_ff <= total_in;
      end
   end

   // classify the order
   always_comb begin
      if (req.entry.favor) begin
         class_raw = LEVEL_FAVOR;
      end else if (req.entry.item_count >= threshold_ff) begin
         class_raw = LEVEL_BULK;
      end else if (req.entry.fast_shipping) begin
         class_raw = LEVEL_FAST;
      end else begin
         class_raw = LEVEL_REGULAR;
      end
      if (class_raw > CLASS_W'(NUM_LEVELS - 1)) begin
         class_lvl = LVL_W'(NUM_LEVELS - 1);
      end else begin
         class_lvl = LVL_W'(class_raw);
      end
   end

   // pick the highest-priority (lowest-numbered) non-empty level
   always_comb begin
      pick_lvl   = '0;
      pick_found = 1'b0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            pick_lvl   = LVL_W'(i);
            pick_found = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
      end
      total_in      = total_ff;
      cmd.wr_en     = 1'b0;
      cmd.wr_addr   = store_addr(class_lvl, tail_ff[class_lvl]);
      cmd.wr_data   = req.entry;
      cmd.rd_en     = 1'b0;
      cmd.rd_addr   = store_addr(pick_lvl, head_ff[pick_lvl]);
      meta.status   = STATUS_DONE;
      meta.level    = '0;
      meta.deq_hit  = 1'b0;
      if (exec) begin
         if (req.func == FUNC_ENQUEUE) begin
            meta.level = class_lvl;
            if (count_ff[class_lvl] >= CNT_W'(QUEUE_DEPTH)) begin
               meta.status = STATUS_FULL;
            end else begin
               cmd.wr_en            = 1'b1;
               tail_in[class_lvl]   = advance(tail_ff[class_lvl]);
               count_in[class_lvl]  = count_ff[class_lvl] + CNT_W'(1);
               total_in             = total_ff + TOTAL_W'(1);
            end
         end else begin
            if (!pick_found) begin
               meta.status = STATUS_EMPTY;
            end else begin
               meta.level          = pick_lvl;
               meta.deq_hit        = 1'b1;
               cmd.rd_en           = 1'b1;
               head_in[pick_lvl]   = advance(head_ff[pick_lvl]);
               count_in[pick_lvl]  = count_ff[pick_lvl] - CNT_W'(1);
               total_in            = total_ff - TOTAL_W'(1);
            end
         end
      end
      meta.total = total_in;
   end

   always_comb begin
      count_sum = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         count_sum = count_sum + TOTAL_W'(count_ff[i]);
      end
   end

   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level_chk
      a_count_bound: assert property (@(posedge clock) disable iff (reset)
         count_ff[g] <= CNT_W'(QUEUE_DEPTH))
         else $error("level count above queue depth");
   end

   a_total_sum: assert property (@(posedge clock) disable iff (reset)
      total_ff == count_sum)
      else $error("running total differs from sum of level counts");

   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      exec && req.func == FUNC_DEQUEUE && total_ff == '0
      |-> meta.status == STATUS_EMPTY && !cmd.rd_en)
      else $error("dequeue with no entries did not report empty");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      exec && meta.status == STATUS_FULL |=> total_ff == $past(total_ff))
      else $error("dropped enqueue changed occupancy");

endmodule

>>> rtl/strict_priority_order_queue_top.sv
// ----------------------------------------------------------------------------
// strict_priority_order_queue_top
// Four-level strict priority order queue with request and response channels.
//
// req_chan carries enqueue and dequeue transactions; rsp_chan returns exactly
// one result transaction per request, in request order. csr_write_en with
// csr_write_data sets the bulk item-count threshold; write it only while no
// transaction is in flight.
// Throughput: one transaction per cycle, sustained while rsp_chan.ready holds.
// A request accepted on req_chan is registered in the input register, then
// executed against the level pointers and the entry memory; its result is
// registered in the output register and offered on rsp_chan from there.
// The entry memory read port is registered and shared by all levels.
// Reset clears all level pointers and counts and loads the threshold with 10;
// no clearing pass runs, so requests are taken right after reset.
// While the receiver stalls, the result holds on rsp_chan, one more request
// is absorbed in the input register, and then req_chan.ready drops.
// ----------------------------------------------------------------------------
module strict_priority_order_queue_top
   import spoq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [THRESH_W-1:0] csr_write_data,
   spoq_req_if.sink            req_chan,
   spoq_rsp_if.source          rsp_chan
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_type         in_req_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   result_meta_type out_meta_ff;
   result_meta_type meta;
   store_cmd_type   cmd;
   entry_type       rd_data;
   logic            out_free;
   logic            exec;
   logic            req_take;

   assign out_free         = !out_valid_ff || rsp_chan.ready;
   assign exec             = in_valid_ff && out_free;
   assign req_chan.ready   = !in_valid_ff || out_free;
   assign req_take         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (exec) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (exec) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.func                   <= req_chan.func;
         in_req_ff.entry.order_id         <= req_chan.order_id;
         in_req_ff.entry.item_count       <= req_chan.item_count;
         in_req_ff.entry.favor            <= req_chan.favor;
         in_req_ff.entry.fast_shipping    <= req_chan.fast_shipping;
      end
      if (exec) begin
         out_meta_ff <= meta;
      end
   end

   spoq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .exec           (exec),
      .req            (in_req_ff),
      .cmd            (cmd),
      .meta           (meta)
   );

   spoq_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_meta_ff.status;
   assign rsp_chan.level        = LEVEL_OUT_W'(out_meta_ff.level);
   assign rsp_chan.total_queued = TOTAL_OUT_W'(out_meta_ff.total);

   always_comb begin
      if (out_meta_ff.deq_hit) begin
         rsp_chan.out_order_id      = rd_data.order_id;
         rsp_chan.out_item_count    = rd_data.item_count;
         rsp_chan.out_favor         = rd_data.favor;
         rsp_chan.out_fast_shipping = rd_data.fast_shipping;
      end else begin
         rsp_chan.out_order_id      = '0;
         rsp_chan.out_item_count    = '0;
         rsp_chan.out_favor         = 1'b0;
         rsp_chan.out_fast_shipping = 1'b0;
      end
   end

endmodule
